// File: hw/rtl/ccm_pkg.sv
`default_nettype none

package ccm_pkg;

  // field widths
  localparam int DEV_W  = 4;
  localparam int CTL_W  = 7;
  localparam int VAL_W  = 7;
  localparam int PROF_W = 4;
  localparam int ATTR_W = 4;
  localparam int DATA_W = 16;

  // parameter defaults
  localparam int MAX_MAPPINGS_DEF    = 32;
  localparam int DEVICE_COUNT_DEF    = 16;
  localparam int PROFILE_COUNT_DEF   = 16;
  localparam int ATTRIBUTE_COUNT_DEF = 16;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_EVENT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_DROPPED = 2'd1,
    ST_MAPPED  = 2'd2
  } status_t;

  // one stored mapping, 51 bits
  typedef struct packed {
    logic [DEV_W-1:0]         dev;
    logic [CTL_W-1:0]         ctl;
    logic [PROF_W-1:0]        prof;
    logic [ATTR_W-1:0]        attr;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
  } entry_t;

  // one result beat
  typedef struct packed {
    status_t                  status;
    logic [PROF_W-1:0]        prof;
    logic [ATTR_W-1:0]        attr;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } result_t;

  // scaler step enables
  typedef struct packed {
    logic span_en;
    logic prod_en;
  } scl_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/ccm_if.sv
`default_nettype none

interface ccm_in_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [ccm_pkg::DEV_W-1:0]         device;
  logic [ccm_pkg::CTL_W-1:0]         controller;
  logic [ccm_pkg::VAL_W-1:0]         cc_value;
  logic [ccm_pkg::PROF_W-1:0]        profile;
  logic [ccm_pkg::ATTR_W-1:0]        attribute;
  logic signed [ccm_pkg::DATA_W-1:0] min_value;
  logic signed [ccm_pkg::DATA_W-1:0] max_value;

  modport source (
    output valid, command, device, controller, cc_value, profile, attribute,
           min_value, max_value,
    input  ready
  );
  modport sink (
    input  valid, command, device, controller, cc_value, profile, attribute,
           min_value, max_value,
    output ready
  );
endinterface

interface ccm_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic [ccm_pkg::PROF_W-1:0]        target_profile;
  logic [ccm_pkg::ATTR_W-1:0]        target_attribute;
  logic signed [ccm_pkg::DATA_W-1:0] scaled_value;
  logic                              last;

  modport source (
    output valid, status, target_profile, target_attribute, scaled_value, last,
    input  ready
  );
  modport sink (
    input  valid, status, target_profile, target_attribute, scaled_value, last,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/ccm_scaler.sv
`default_nettype none

// min + floor((max - min) * value / 128), one multiply shared by all matches
module ccm_scaler (
  input  wire logic                              clk,
  input  wire ccm_pkg::scl_ctrl_t                ctrl,
  input  wire logic signed [ccm_pkg::DATA_W-1:0] lo,
  input  wire logic signed [ccm_pkg::DATA_W-1:0] hi,
  input  wire logic [ccm_pkg::VAL_W-1:0]         val,
  output logic signed [ccm_pkg::DATA_W-1:0]      result
);

  localparam int SPAN_W    = ccm_pkg::DATA_W + 1;
  localparam int PROD_W    = SPAN_W + ccm_pkg::VAL_W;
  localparam int QUOT_W    = PROD_W - ccm_pkg::VAL_W;
  localparam int DATA_W_P2 = ccm_pkg::DATA_W + 2;

  logic signed [SPAN_W-1:0]    span_r;
  logic signed [PROD_W-1:0]    prod_r;
  logic signed [PROD_W-1:0]    prod_full;
  logic signed [QUOT_W-1:0]    quot;
  logic signed [DATA_W_P2-1:0] sum;

  // span and product, one step each
  assign prod_full = span_r * $signed({1'b0, val});

  always_ff @(posedge clk) begin
    if (ctrl.span_en) begin
      span_r <= $signed({hi[ccm_pkg::DATA_W-1], hi}) - $signed({lo[ccm_pkg::DATA_W-1], lo});
    end
    if (ctrl.prod_en) begin
      prod_r <= prod_full;
    end
  end

  // arithmetic shift floors toward minus infinity
  assign quot   = prod_r[PROD_W-1:ccm_pkg::VAL_W];
  assign sum    = $signed({{2{lo[ccm_pkg::DATA_W-1]}}, lo})
                + $signed({{(DATA_W_P2-QUOT_W){quot[QUOT_W-1]}}, quot});
  assign result = sum[ccm_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/cc_controller_mapping_table.sv
`default_nettype none

// channel  dir  beat contents
// in_bus   in   command, device, controller, cc_value, profile, attribute, min, max
// out_bus  out  status, target_profile, target_attribute, scaled_value, last
//
// An add passes from accept through the pending register (S_ADD) into the output register.
// An event scans the stored mappings newest first, one entry per read of the mapping
// memory, and each match uses the shared multiplier once.
// Reset (synchronous, rst_n low) empties the table; entries need no clearing.
// Input is taken only when the sequencer is idle; a stalled output holds the scan.

module cc_controller_mapping_table #(
  parameter int MAX_MAPPINGS    = ccm_pkg::MAX_MAPPINGS_DEF,
  parameter int DEVICE_COUNT    = ccm_pkg::DEVICE_COUNT_DEF,
  parameter int PROFILE_COUNT   = ccm_pkg::PROFILE_COUNT_DEF,
  parameter int ATTRIBUTE_COUNT = ccm_pkg::ATTRIBUTE_COUNT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ccm_in_if.sink     in_bus,
  ccm_out_if.source  out_bus
);

  localparam int IDX_W = $clog2(MAX_MAPPINGS);
  localparam int CNT_W = $clog2(MAX_MAPPINGS + 1);
  localparam int LIM_W = 9;
  localparam logic [LIM_W-1:0] DEV_LIM  = LIM_W'(DEVICE_COUNT);
  localparam logic [LIM_W-1:0] PROF_LIM = LIM_W'(PROFILE_COUNT);
  localparam logic [LIM_W-1:0] ATTR_LIM = LIM_W'(ATTRIBUTE_COUNT);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_MAPPINGS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ADD   = 7'b0000010,
    S_FETCH = 7'b0000100,
    S_TEST  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_PUSH  = 7'b0100000,
    S_FLUSH = 7'b1000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic [CNT_W-1:0]                idx_r, idx_nxt;
  logic [CNT_W-1:0]                idx_dec;
  logic [ccm_pkg::DEV_W-1:0]       dev_r, dev_nxt;
  logic [ccm_pkg::CTL_W-1:0]       ctl_r, ctl_nxt;
  logic [ccm_pkg::VAL_W-1:0]       val_r, val_nxt;
  ccm_pkg::result_t                pend_r, pend_nxt;
  logic                            pend_valid_r, pend_valid_nxt;
  ccm_pkg::result_t                out_r, out_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ccm_pkg::entry_t                 mem [MAX_MAPPINGS];
  ccm_pkg::entry_t                 rd_r;
  ccm_pkg::entry_t                 wr_entry;
  logic                            wr_en;
  logic                            rd_en;
  logic                            accept;
  logic                            add_ok;
  logic                            out_free;
  logic                            hit;
  ccm_pkg::scl_ctrl_t              scl_ctrl;
  logic signed [ccm_pkg::DATA_W-1:0] scl_result;

  assign accept   = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;
  assign idx_dec  = idx_r - 1'b1;
  assign hit      = (rd_r.dev == dev_r) && (rd_r.ctl == ctl_r);

  assign add_ok = (count_r < CNT_MAX)
               && (LIM_W'(in_bus.device)    < DEV_LIM)
               && (LIM_W'(in_bus.profile)   < PROF_LIM)
               && (LIM_W'(in_bus.attribute) < ATTR_LIM);

  assign wr_entry = '{dev:  in_bus.device,    ctl: in_bus.controller,
                      prof: in_bus.profile,   attr: in_bus.attribute,
                      lo:   in_bus.min_value, hi:  in_bus.max_value};
  assign wr_en = accept && (in_bus.command == ccm_pkg::CMD_ADD) && add_ok;
  assign rd_en = (state_r == S_FETCH);

  // mapping memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= wr_entry;
    end
    if (rd_en) begin
      rd_r <= mem[idx_dec[IDX_W-1:0]];
    end
  end

  ccm_scaler u_scaler (
    .clk    (clk),
    .ctrl   (scl_ctrl),
    .lo     (rd_r.lo),
    .hi     (rd_r.hi),
    .val    (val_r),
    .result (scl_result)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    dev_nxt        = dev_r;
    ctl_nxt        = ctl_r;
    val_nxt        = val_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    scl_ctrl       = '{span_en: 1'b0, prod_en: 1'b0};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_bus.command == ccm_pkg::CMD_ADD) begin
            pend_nxt = '{status: add_ok ? ccm_pkg::ST_ADDED : ccm_pkg::ST_DROPPED,
                         prof: in_bus.profile, attr: in_bus.attribute,
                         value: '0, last: 1'b1};
            if (add_ok) begin
              count_nxt = count_r + 1'b1;
            end
            state_nxt = S_ADD;
          end else begin
            dev_nxt   = in_bus.device;
            ctl_nxt   = in_bus.controller;
            val_nxt   = in_bus.cc_value;
            idx_nxt   = count_r;
            state_nxt = (count_r == '0) ? S_FLUSH : S_FETCH;
          end
        end
      end
      S_ADD: begin
        if (out_free) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_FETCH: begin
        idx_nxt   = idx_dec;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (hit) begin
          scl_ctrl.span_en = 1'b1;
          state_nxt        = S_MUL;
        end else begin
          state_nxt = (idx_r == '0) ? S_FLUSH : S_FETCH;
        end
      end
      S_MUL: begin
        scl_ctrl.prod_en = 1'b1;
        state_nxt        = S_PUSH;
      end
      S_PUSH: begin
        // the held match goes out only once the next match found proves it is not last
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_nxt       = pend_r;
            out_valid_nxt = 1'b1;
          end
          pend_nxt       = '{status: ccm_pkg::ST_MAPPED, prof: rd_r.prof,
                             attr: rd_r.attr, value: scl_result, last: 1'b0};
          pend_valid_nxt = 1'b1;
          state_nxt      = (idx_r == '0) ? S_FLUSH : S_FETCH;
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_nxt        = pend_r;
          out_nxt.last   = 1'b1;
          out_valid_nxt  = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    dev_r  <= dev_nxt;
    ctl_r  <= ctl_nxt;
    val_r  <= val_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign in_bus.ready             = (state_r == S_IDLE);
  assign out_bus.valid            = out_valid_r;
  assign out_bus.status           = out_r.status;
  assign out_bus.target_profile   = out_r.prof;
  assign out_bus.target_attribute = out_r.attr;
  assign out_bus.scaled_value     = out_r.value;
  assign out_bus.last             = out_r.last;

endmodule

`default_nettype wire

// File: hw/rtl/ccm_checker.sv
`default_nettype none

module ccm_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [1:0]                  out_status,
  input wire logic [ccm_pkg::PROF_W-1:0]  out_prof,
  input wire logic [ccm_pkg::ATTR_W-1:0]  out_attr,
  input wire logic [ccm_pkg::DATA_W-1:0]  out_value,
  input wire logic                        out_last
);

  // a stalled result beat holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_prof)
      && $stable(out_attr) && $stable(out_value) && $stable(out_last))
    else $error("result beat changed while stalled");

  // every accepted input drops ready, so no two inputs are taken back to back
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // add answers are single beats
  a_add_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ccm_pkg::ST_MAPPED |-> out_last)
    else $error("add answer without last");

  // the status is always one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ccm_pkg::ST_ADDED || out_status == ccm_pkg::ST_DROPPED
      || out_status == ccm_pkg::ST_MAPPED)
    else $error("unknown status code");

  // nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind cc_controller_mapping_table ccm_checker u_ccm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .out_status(out_bus.status),
  .out_prof  (out_bus.target_profile),
  .out_attr  (out_bus.target_attribute),
  .out_value (out_bus.scaled_value),
  .out_last  (out_bus.last)
);

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEV_W       = ccm_pkg::DEV_W;
  localparam int CTL_W       = ccm_pkg::CTL_W;
  localparam int VAL_W       = ccm_pkg::VAL_W;
  localparam int PROF_W      = ccm_pkg::PROF_W;
  localparam int ATTR_W      = ccm_pkg::ATTR_W;
  localparam int DATA_W      = ccm_pkg::DATA_W;
  localparam int MAX_MAP     = ccm_pkg::MAX_MAPPINGS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  // settle time, with margin over the longest event scan with no result
  localparam int SETTLE      = 150;

  // one input beat as the sender sees it
  typedef struct packed {
    ccm_pkg::cmd_t            cmd;
    logic [DEV_W-1:0]         dev;
    logic [CTL_W-1:0]         ctl;
    logic [VAL_W-1:0]         val;
    logic [PROF_W-1:0]        prof;
    logic [ATTR_W-1:0]        attr;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
  } cc_beat_t;

  logic clk;
  logic rst_n;

  ccm_in_if  in_bus ();
  ccm_out_if out_bus ();

  cc_controller_mapping_table dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // shadow copy of the mapping table
  ccm_pkg::entry_t map_table [MAX_MAP];
  int unsigned     map_count;

  // results still owed by the block, oldest first
  ccm_pkg::result_t awaited_results [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned rx_hold_req;
  int unsigned burst_left;
  bit          gaps_on;

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // min + floor(span * v / 128); arithmetic shift floors toward minus infinity
  function automatic logic signed [DATA_W-1:0] scale_span(logic signed [DATA_W-1:0] lo,
                                                           logic signed [DATA_W-1:0] hi,
                                                           logic [VAL_W-1:0] v);
    longint span;
    longint prod;
    span = longint'(hi) - longint'(lo);
    prod = span * longint'(v);
    return DATA_W'(longint'(lo) + (prod >>> 7));
  endfunction

  // update the shadow table and queue the results one accepted beat causes
  function automatic void table_apply(cc_beat_t b);
    ccm_pkg::result_t r;
    ccm_pkg::result_t hits [$];
    bit               ok;
    if (b.cmd == ccm_pkg::CMD_ADD) begin
      ok = map_count < MAX_MAP && b.dev < ccm_pkg::DEVICE_COUNT_DEF &&
           b.prof < ccm_pkg::PROFILE_COUNT_DEF && b.attr < ccm_pkg::ATTRIBUTE_COUNT_DEF;
      if (ok) begin
        map_table[map_count] = '{dev: b.dev, ctl: b.ctl, prof: b.prof, attr: b.attr,
                                 lo: b.lo, hi: b.hi};
        map_count++;
      end
      r.status = ok ? ccm_pkg::ST_ADDED : ccm_pkg::ST_DROPPED;
      r.prof   = b.prof;
      r.attr   = b.attr;
      r.value  = '0;
      r.last   = 1'b1;
      awaited_results.push_back(r);
    end else begin
      // newest mapping first
      for (int i = int'(map_count) - 1; i >= 0; i--) begin
        if (map_table[i].dev == b.dev && map_table[i].ctl == b.ctl) begin
          r.status = ccm_pkg::ST_MAPPED;
          r.prof   = map_table[i].prof;
          r.attr   = map_table[i].attr;
          r.value  = scale_span(map_table[i].lo, map_table[i].hi, b.val);
          r.last   = 1'b0;
          hits.push_back(r);
        end
      end
      if (hits.size() != 0) hits[hits.size()-1].last = 1'b1;
      foreach (hits[k]) awaited_results.push_back(hits[k]);
    end
  endfunction

  function automatic cc_beat_t mk_add(int dev, int ctl, int prof, int attr, int lo, int hi);
    cc_beat_t b;
    b.cmd  = ccm_pkg::CMD_ADD;
    b.dev  = DEV_W'(dev);
    b.ctl  = CTL_W'(ctl);
    b.val  = '0;
    b.prof = PROF_W'(prof);
    b.attr = ATTR_W'(attr);
    b.lo   = DATA_W'(lo);
    b.hi   = DATA_W'(hi);
    return b;
  endfunction

  function automatic cc_beat_t mk_event(int dev, int ctl, int val);
    cc_beat_t b;
    b      = mk_add(dev, ctl, 0, 0, 0, 0);
    b.cmd  = ccm_pkg::CMD_EVENT;
    b.val  = VAL_W'(val);
    return b;
  endfunction

  // events mostly aimed at stored mappings, adds mostly drawn from a small key pool
  function automatic cc_beat_t random_beat(int unsigned add_pct);
    cc_beat_t    b;
    int unsigned pick;
    int unsigned k;
    b.cmd  = ($urandom_range(1, 100) <= add_pct) ? ccm_pkg::CMD_ADD : ccm_pkg::CMD_EVENT;
    b.dev  = DEV_W'($urandom);
    b.ctl  = CTL_W'($urandom);
    b.val  = VAL_W'($urandom);
    b.prof = PROF_W'($urandom);
    b.attr = ATTR_W'($urandom);
    b.lo   = DATA_W'($urandom);
    b.hi   = DATA_W'($urandom);
    pick   = $urandom_range(0, 99);
    if (b.cmd == ccm_pkg::CMD_EVENT && map_count != 0 && pick < 70) begin
      k     = $urandom_range(0, map_count - 1);
      b.dev = map_table[k].dev;
      b.ctl = map_table[k].ctl;
    end else if (pick < 80) begin
      b.dev = DEV_W'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0: b.ctl = CTL_W'(0);
        1: b.ctl = CTL_W'(5);
        2: b.ctl = CTL_W'(64);
        default: b.ctl = CTL_W'(127);
      endcase
    end
    // pull bounds and value to the edges now and then
    case ($urandom_range(0, 9))
      0: b.lo = 16'sh8000;
      1: b.hi = 16'sh7fff;
      2: begin
        b.lo = 16'sh7fff;
        b.hi = 16'sh8000;
      end
      3: b.hi = b.lo;
      4: b.val = '1;
      5: b.val = '0;
      default: ;
    endcase
    return b;
  endfunction

  // offer one beat and wait for the handshake; gaps come between bursts
  task automatic send_beat(input cc_beat_t b);
    if (gaps_on && burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    in_bus.valid      <= 1'b1;
    in_bus.command    <= b.cmd;
    in_bus.device     <= b.dev;
    in_bus.controller <= b.ctl;
    in_bus.cc_value   <= b.val;
    in_bus.profile    <= b.prof;
    in_bus.attribute  <= b.attr;
    in_bus.min_value  <= b.lo;
    in_bus.max_value  <= b.hi;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    table_apply(b);
  endtask

  // stop offering and wait until every owed result has come out
  task automatic wait_for_drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    ccm_pkg::result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d prof %0d attr %0d value %0d last %0d",
                   out_bus.status, out_bus.target_profile, out_bus.target_attribute,
                   out_bus.scaled_value, out_bus.last);
      end else begin
        want = awaited_results.pop_front();
        if (out_bus.status !== want.status || out_bus.target_profile !== want.prof ||
            out_bus.target_attribute !== want.attr || out_bus.scaled_value !== want.value ||
            out_bus.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display(
              "mismatch (st prof attr val last): want %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
              want.status, want.prof, want.attr, want.value, want.last,
              out_bus.status, out_bus.target_profile, out_bus.target_attribute,
              out_bus.scaled_value, out_bus.last);
        end
      end
    end
  end

  // receiver stall pattern, plus long hold-offs on request
  initial begin : rx_pattern
    int unsigned hold_left;
    int unsigned run_left;
    int unsigned mode;
    hold_left     = 0;
    run_left      = 0;
    mode          = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (run_left == 0) begin
        mode     = $urandom_range(0, 2);
        run_left = $urandom_range(8, 40);
      end
      run_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 3) != 0);
          default: out_bus.ready <= run_left[0];
        endcase
      end
    end
  end

  // extremes, reversed ranges, floor on negative spans, misses, multiple matches
  task automatic test_directed();
    send_beat(mk_event(0, 0, 5));
    send_beat(mk_add(15, 127, 15, 15, -32768, 32767));
    send_beat(mk_event(15, 127, 0));
    send_beat(mk_event(15, 127, 127));
    send_beat(mk_event(15, 127, 64));
    send_beat(mk_add(0, 0, 0, 0, 32767, -32768));
    send_beat(mk_event(0, 0, 1));
    send_beat(mk_event(0, 0, 127));
    send_beat(mk_add(0, 0, 5, 10, 0, 256));
    send_beat(mk_add(0, 0, 3, 12, -256, -1));
    send_beat(mk_event(0, 0, 100));
    send_beat(mk_event(0, 1, 100));
    send_beat(mk_event(1, 0, 100));
    send_beat(mk_add(2, 64, 7, 8, 0, -3));
    send_beat(mk_event(2, 64, 1));
    send_beat(mk_event(2, 64, 127));
    send_beat(mk_add(9, 85, 10, 5, 1234, 1234));
    send_beat(mk_event(9, 85, 99));
    send_beat(mk_event(15, 127, 85));
  endtask

  // mixed traffic with idling switched on and off in chunks
  task automatic test_random_traffic(int unsigned count, int unsigned add_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 30 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      send_beat(random_beat(add_pct));
    end
    gaps_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    gaps_on     = 1'b0;
    rx_hold_req = 400;
    repeat (14) send_beat(random_beat(30));
    gaps_on = 1'b1;
    wait_for_drain();
  endtask

  // sender pauses until the block has answered everything
  task automatic test_drain_pause();
    repeat (10) send_beat(random_beat(30));
    wait_for_drain();
    repeat (10) send_beat(random_beat(30));
  endtask

  // fill the table, then adds past the end are dropped
  task automatic test_table_full();
    int unsigned room;
    room = MAX_MAP - map_count;
    repeat (room + 4) send_beat(random_beat(100));
    repeat (8) send_beat(random_beat(0));
  endtask

  initial begin : main
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.command    = ccm_pkg::CMD_ADD;
    in_bus.device     = '0;
    in_bus.controller = '0;
    in_bus.cc_value   = '0;
    in_bus.profile    = '0;
    in_bus.attribute  = '0;
    in_bus.min_value  = '0;
    in_bus.max_value  = '0;
    map_count         = 0;
    mismatch_count    = 0;
    cycle_count       = 0;
    rx_hold_req       = 0;
    burst_left        = 0;
    gaps_on           = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_traffic(100, 35);
    test_backpressure();
    test_drain_pause();
    test_table_full();
    test_random_traffic(30, 20);

    wait_for_drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/ccm_pkg.sv
hw/rtl/ccm_if.sv
hw/rtl/ccm_scaler.sv
hw/rtl/cc_controller_mapping_table.sv
hw/rtl/ccm_checker.sv
tb/tb.sv
